// File: rtl/bgrf_pkg.sv
package bgrf_pkg;

   localparam int BUFFER_BITS_DEF = 4096;
   localparam int VALUE_W         = 64;
   localparam int COUNT_W         = 7;
   localparam int FREE_W          = 13;
   localparam int REQ_DATA_W      = 72;
   localparam int RSP_DATA_W      = 80;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] MAX_BITS = COUNT_W'(64);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      B_IDLE,
      B_RUN
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   value;
      logic [COUNT_W-1:0]   count;
      status_type           status;
      logic [FREE_W-1:0]    free_bits;
   } cmd_type;

   // ones in the low n bits of a byte, n from 0 to 8
   function automatic logic [7:0] low_mask(input logic [3:0] n);
      low_mask = 8'hFF >> (4'd8 - n);
   endfunction

endpackage

// File: rtl/bgrf_front.sv
module bgrf_front #(
   parameter int BUFFER_BITS = bgrf_pkg::BUFFER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bgrf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                q_ready,
   output logic                                q_push,
   output bgrf_pkg::cmd_type                   q_cmd
);
   import bgrf_pkg::*;

   localparam int FW = $clog2(BUFFER_BITS + 1);

   logic [FW-1:0]      free_ff;
   logic [FW-1:0]      free_in;
   logic [FW-1:0]      held;
   logic [FW-1:0]      cnt_wide;
   logic [COUNT_W-1:0] cnt_raw;
   logic [COUNT_W-1:0] cnt;
   op_type             op;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;
   assign op         = op_type'(req_tuser);
   assign cnt_raw    = req_tdata[VALUE_W +: COUNT_W];
   assign cnt        = (cnt_raw > MAX_BITS) ? MAX_BITS : cnt_raw;
   assign cnt_wide   = FW'(cnt);
   assign held       = FW'(BUFFER_BITS) - free_ff;

   always_comb begin
      free_in        = free_ff;
      q_cmd.op       = op;
      q_cmd.value    = req_tdata[VALUE_W-1:0];
      q_cmd.count    = cnt;
      q_cmd.status   = ST_DONE;
      unique case (op)
         OP_WRITE: begin
            if (cnt_wide > free_ff) begin
               q_cmd.status = ST_OVERFLOW;
               q_cmd.count  = '0;
            end else begin
               free_in = free_ff - cnt_wide;
            end
         end
         OP_READ: begin
            if (cnt_wide > held) begin
               q_cmd.status = ST_UNDERFLOW;
               q_cmd.count  = '0;
            end else begin
               free_in = free_ff + cnt_wide;
            end
         end
         default: begin
            free_in = free_ff;
         end
      endcase
      q_cmd.free_bits = FREE_W'(free_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= FW'(BUFFER_BITS);
      end else if (q_push) begin
         free_ff <= free_in;
      end
   end

endmodule

// File: rtl/bgrf_queue.sv
module bgrf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              in_ready,
   input  bgrf_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              out_valid,
   output bgrf_pkg::cmd_type pop_cmd
);
   import bgrf_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_idx_ff;
   logic [QUEUE_AW-1:0]    rd_idx_ff;
   logic [QUEUE_CW-1:0]    count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign in_ready  = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_idx_ff];
   assign do_push   = push & in_ready;
   assign do_pop    = pop & out_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_idx_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_idx_ff <= (wr_idx_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
         end
         if (do_pop) begin
            rd_idx_ff <= (rd_idx_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/bgrf_back.sv
module bgrf_back #(
   parameter int BUFFER_BITS = bgrf_pkg::BUFFER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  bgrf_pkg::cmd_type                   q_cmd,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bgrf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser
);
   import bgrf_pkg::*;

   localparam int PW          = $clog2(BUFFER_BITS);
   localparam int AW          = PW - 3;
   localparam int STORE_BYTES = (BUFFER_BITS + 7) / 8;

   logic [7:0]          store_mem [STORE_BYTES];
   logic [7:0]          rd_data_ff;

   back_state_type      state_ff, state_in;
   op_type              op_ff, op_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  pos_ff, pos_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic                mem_valid_ff, mem_valid_in;
   status_type          status_ff, status_in;
   logic [FREE_W-1:0]   free_ff, free_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FREE_W-1:0]   rsp_free_ff, rsp_free_in;

   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [7:0]          mem_wdata;

   logic [2:0]          offs;
   logic [3:0]          room_byte;
   logic [PW:0]         room_ring;
   logic [3:0]          n_byte;
   logic [3:0]          n;
   logic [7:0]          mask;
   logic [PW:0]         ptr_sum;
   logic [PW-1:0]       next_ptr;
   logic                need_data;
   logic [7:0]          rd_bits;

   // bits of the current byte touched in this step
   always_comb begin
      offs      = ptr_ff[2:0];
      room_byte = 4'd8 - {1'b0, offs};
      room_ring = (PW + 1)'(BUFFER_BITS) - {1'b0, ptr_ff};
      n_byte    = (rem_ff > COUNT_W'(room_byte)) ? room_byte : rem_ff[3:0];
      n         = (room_ring < (PW + 1)'(n_byte)) ? room_ring[3:0] : n_byte;
      mask      = 8'(low_mask(n) << offs);
      ptr_sum   = {1'b0, ptr_ff} + (PW + 1)'(n);
      next_ptr  = (ptr_sum == (PW + 1)'(BUFFER_BITS)) ? '0 : ptr_sum[PW-1:0];
      need_data = (op_ff == OP_READ) || (mask != 8'hFF);
      rd_bits   = 8'(rd_data_ff >> offs) & low_mask(n);
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ptr_in        = ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      mem_valid_in  = mem_valid_ff;
      status_in     = status_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = ptr_ff[PW-1:3];
      mem_raddr     = ptr_ff[PW-1:3];
      mem_wdata     = (rd_data_ff & ~mask) | (8'(acc_ff[7:0] << offs) & mask);

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_tready)) begin
               q_pop = 1'b1;
               if (q_cmd.count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = q_cmd.status;
                  rsp_free_in   = q_cmd.free_bits;
               end else begin
                  state_in     = B_RUN;
                  op_in        = q_cmd.op;
                  ptr_in       = (q_cmd.op == OP_READ) ? rd_ptr_ff : wr_ptr_ff;
                  rem_in       = q_cmd.count;
                  pos_in       = '0;
                  acc_in       = (q_cmd.op == OP_READ) ? '0 : q_cmd.value;
                  mem_valid_in = 1'b0;
                  status_in    = q_cmd.status;
                  free_in      = q_cmd.free_bits;
               end
            end
         end
         B_RUN: begin
            if (need_data && !mem_valid_ff) begin
               mem_re       = 1'b1;
               mem_valid_in = 1'b1;
            end else begin
               if (op_ff == OP_WRITE) begin
                  mem_we       = 1'b1;
                  acc_in       = acc_ff >> n;
                  mem_valid_in = 1'b0;
               end else begin
                  acc_in       = acc_ff | (VALUE_W'(rd_bits) << pos_ff);
                  mem_re       = 1'b1;
                  mem_raddr    = next_ptr[PW-1:3];
                  mem_valid_in = 1'b1;
               end
               ptr_in = next_ptr;
               rem_in = rem_ff - COUNT_W'(n);
               pos_in = pos_ff + COUNT_W'(n);
               if (rem_ff == COUNT_W'(n)) begin
                  state_in      = B_IDLE;
                  mem_valid_in  = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = (op_ff == OP_READ) ? acc_in : '0;
                  rsp_status_in = status_ff;
                  rsp_free_in   = free_ff;
                  if (op_ff == OP_READ) begin
                     rd_ptr_in = next_ptr;
                  end else begin
                     wr_ptr_in = next_ptr;
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         mem_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         mem_valid_ff <= mem_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      free_ff       <= free_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VALUE_W - FREE_W)'(0), rsp_free_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/bit_granular_ring_fifo_top.sv
// Bit-granular ring FIFO. Each item writes the low 0 to 64 bits of a value
// into a ring of BUFFER_BITS bits, lsb first, or reads 0 to 64 bits back in
// the same order; counts above 64 are taken as 64. A write larger than the
// free space is refused with overflow status, a read larger than the bits
// held with underflow status, and neither changes anything. Every item gives
// one result carrying the bits read, the status and the free bit count.
// Items are checked and counted on entry and queued two deep, so the input
// side keeps taking items while the byte store works, until the queue is
// full. The single-port byte store makes one byte access a cycle: a refused
// or empty item is answered without touching it, a read fetches every byte
// touched, and a write stores whole bytes directly and reads back each partly
// written byte before rewriting it. No clearing pass after reset.
module bit_granular_ring_fifo_top #(
   parameter int BUFFER_BITS = bgrf_pkg::BUFFER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // write_value[63:0], bit_count[70:64], zero pad
   input  logic [bgrf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_value[63:0], free_bits[76:64], zero pad
   output logic [bgrf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [1:0]                          rsp_tuser
);
   import bgrf_pkg::*;

   logic    q_ready;
   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   bgrf_front #(
      .BUFFER_BITS(BUFFER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   bgrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .in_ready  (q_ready),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .out_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   bgrf_back #(
      .BUFFER_BITS(BUFFER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
